@@ rtl/rrt_pkg.sv @@
// rrt_pkg: shared types and codes for the replay reservation table
// entry layout, request codes and status codes; no dependencies
package rrt_pkg;

   localparam int unsigned HashMul   = 31;
   localparam int unsigned FoldShift = 32;

   localparam logic [1:0] REQ_LOOKUP = 2'd0;
   localparam logic [1:0] REQ_SET    = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RESERVED  = 3'd1;
   localparam logic [2:0] ST_DUPLICATE = 3'd2;
   localparam logic [2:0] ST_PENDING   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;
   localparam logic [2:0] ST_MISSING   = 3'd5;

   localparam int unsigned DefBuckets = 256;
   localparam int unsigned DefWays    = 4;

   typedef struct packed {
      logic        valid;
      logic        attached;
      logic [63:0] client0;
      logic [63:0] client1;
      logic [63:0] create0;
      logic [63:0] create1;
      logic [31:0] handle;
   } entry_type;

endpackage

@@ rtl/rrt_ram.sv @@
// rrt_ram: generic single write port, single read port ram
// registered read data held until the next read; no dependencies
module rrt_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/replay_reservation_table.sv @@
// replay_reservation_table: set associative table of 128+128 bit keys with reservation
// depends on rrt_pkg and rrt_ram
//
//  channel   | ports                              | handshake
//  ----------+------------------------------------+------------------------------
//  request   | req_type, req_*_word*, req_replay, | taken when start & !busy
//            | req_handle_in                      |
//  response  | rsp_status, rsp_handle_out         | rsp_valid, one cycle, no stall
//
// a request takes 3 hash steps, 5 bucket steps (multiply by the reciprocal, multiply
// back, subtract, two corrections), 1 read, WAYS scan steps and 1 update, run in turn;
// busy stays high throughout. the two multiply steps share one multiplier, and the ram
// has a single read port.
// the response strobe follows in the cycle after the update, when busy is already low.
// after reset a clearing pass writes every bucket row to zero, and busy stays high
// meanwhile. the response cannot be stalled.
module replay_reservation_table #(
   parameter int unsigned BUCKETS = rrt_pkg::DefBuckets,
   parameter int unsigned WAYS    = rrt_pkg::DefWays
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_client_id_word0,
   input  logic [63:0] req_client_id_word1,
   input  logic [63:0] req_create_id_word0,
   input  logic [63:0] req_create_id_word1,
   input  logic        req_replay_flag,
   input  logic [31:0] req_handle_in,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_handle_out
);

   // bucket address, remainder and way index widths
   localparam int unsigned BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned RW  = BW + 2;
   localparam int unsigned WW  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int unsigned EW  = $bits(rrt_pkg::entry_type);
   localparam logic [BW-1:0]  LastBucket  = BW'(BUCKETS - 1);
   localparam logic [RW-1:0]  BucketsVal  = RW'(BUCKETS);
   localparam logic [31:0]    BucketsWide = 32'(BUCKETS);
   // floor((2^32 - 1) / BUCKETS): quotient estimate low by at most two
   localparam logic [31:0]    Recip       = 32'(64'hFFFF_FFFF / 64'(BUCKETS));
   localparam logic [4:0]     LastHash   = 5'd2;
   localparam logic [4:0]     StepRecip  = 5'd0;
   localparam logic [4:0]     StepSub    = 5'd2;
   localparam logic [4:0]     LastMod    = 5'd4;
   localparam logic [4:0]     LastWay    = 5'(WAYS - 1);

   typedef rrt_pkg::entry_type [WAYS-1:0] row_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_SCAN, S_UPDATE
   } state_type;

   state_type   state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [BW-1:0] clr_ff, clr_in;

   // latched request word
   logic [1:0]  type_ff, type_in;
   logic [63:0] cl0_ff, cl0_in, cl1_ff, cl1_in, cr0_ff, cr0_in, cr1_ff, cr1_in;
   logic        replay_ff, replay_in;
   logic [31:0] hin_ff, hin_in;

   // hash and bucket datapath
   logic [63:0]  hash_ff, hash_in;
   logic [31:0]  fold_ff, fold_in;
   logic [RW-1:0] rem_ff, rem_in;
   logic [63:0]  prod_ff, prod_in;
   logic [63:0]  hash_word;
   logic [31:0]  mul_a, mul_b;
   logic [63:0]  mul_p;
   logic [31:0]  diff;

   // scan results
   logic          found_ff, found_in, free_ff, free_in;
   logic [WW-1:0] match_ff, match_in, freew_ff, freew_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [31:0] hout_ff, hout_in;

   // ram port
   logic          wr_en, rd_en;
   logic [BW-1:0] wr_addr;
   logic [EW*WAYS-1:0] wr_data, rd_data;
   row_type       row, new_row;
   rrt_pkg::entry_type cur, hit;
   logic [2:0]    status_c;
   logic [31:0]   hout_c;
   logic          write_c;

   rrt_ram #(.WIDTH(EW * WAYS), .DEPTH(BUCKETS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rem_ff[BW-1:0]),
      .rd_data (rd_data)
   );

   assign row = row_type'(rd_data);
   assign cur = row[cnt_ff[WW-1:0]];
   assign hit = row[match_ff];

   // one step of h = h*31 + word, as shift and subtract
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    hash_word = cl1_ff;
         2'd1:    hash_word = cr0_ff;
         default: hash_word = cr1_ff;
      endcase
   end

   // shared multiplier: fold times reciprocal, then quotient estimate times buckets
   assign mul_a = (cnt_ff == StepRecip) ? fold_ff : prod_ff[63:32];
   assign mul_b = (cnt_ff == StepRecip) ? Recip : BucketsWide;
   assign mul_p = 64'(mul_a) * 64'(mul_b);
   // remainder estimate, below three times the bucket count
   assign diff  = fold_ff - prod_ff[31:0];

   // update decision on the scanned row
   always_comb begin
      new_row  = row;
      status_c = rrt_pkg::ST_MISSING;
      hout_c   = '0;
      write_c  = 1'b0;
      case (type_ff)
         rrt_pkg::REQ_LOOKUP: begin
            if (!found_ff) begin
               if (free_ff) begin
                  new_row[freew_ff].valid    = 1'b1;
                  new_row[freew_ff].attached = 1'b0;
                  new_row[freew_ff].client0  = cl0_ff;
                  new_row[freew_ff].client1  = cl1_ff;
                  new_row[freew_ff].create0  = cr0_ff;
                  new_row[freew_ff].create1  = cr1_ff;
                  status_c = rrt_pkg::ST_RESERVED;
                  write_c  = 1'b1;
               end else begin
                  status_c = rrt_pkg::ST_FULL;
               end
            end else if (hit.attached) begin
               if (replay_ff) begin
                  status_c = rrt_pkg::ST_OK;
                  hout_c   = hit.handle;
               end else begin
                  status_c = rrt_pkg::ST_DUPLICATE;
               end
            end else begin
               status_c = rrt_pkg::ST_PENDING;
            end
         end
         rrt_pkg::REQ_SET: begin
            if (found_ff && !hit.attached) begin
               new_row[match_ff].attached = 1'b1;
               new_row[match_ff].handle   = hin_ff;
               status_c = rrt_pkg::ST_OK;
               write_c  = 1'b1;
            end
         end
         rrt_pkg::REQ_CLEAR: begin
            if (found_ff) begin
               new_row[match_ff].valid    = 1'b0;
               new_row[match_ff].attached = 1'b0;
               status_c = rrt_pkg::ST_OK;
               write_c  = 1'b1;
            end
         end
         default: begin
            status_c = rrt_pkg::ST_MISSING;
         end
      endcase
   end

   // ram write: zero rows during the clearing pass, else the updated row
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rem_ff[BW-1:0];
      wr_data = (EW * WAYS)'(new_row);
      rd_en   = (state_ff == S_READ);
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (state_ff == S_UPDATE) begin
         wr_en = write_c;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      type_in      = type_ff;
      cl0_in       = cl0_ff;
      cl1_in       = cl1_ff;
      cr0_in       = cr0_ff;
      cr1_in       = cr1_ff;
      replay_in    = replay_ff;
      hin_in       = hin_ff;
      hash_in      = hash_ff;
      fold_in      = fold_ff;
      rem_in       = rem_ff;
      prod_in      = prod_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      match_in     = match_ff;
      freew_in     = freew_ff;
      rsp_valid_in = 1'b0;
      status_in    = status_ff;
      hout_in      = hout_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LastBucket) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               type_in   = req_type;
               cl0_in    = req_client_id_word0;
               cl1_in    = req_client_id_word1;
               cr0_in    = req_create_id_word0;
               cr1_in    = req_create_id_word1;
               replay_in = req_replay_flag;
               hin_in    = req_handle_in;
               hash_in   = req_create_id_word0;
               cnt_in    = '0;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            hash_in = (hash_ff << 5) - hash_ff + hash_word;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LastHash) begin
               state_in = S_MOD;
               cnt_in   = '0;
               rem_in   = '0;
               fold_in  = hash_in[63:rrt_pkg::FoldShift] ^
                          hash_in[rrt_pkg::FoldShift-1:0];
            end
         end
         S_MOD: begin
            // bucket = fold mod BUCKETS by reciprocal multiply and two corrections
            if (cnt_ff == StepSub) begin
               rem_in = diff[RW-1:0];
            end else if (cnt_ff > StepSub) begin
               if (rem_ff >= BucketsVal) begin
                  rem_in = rem_ff - BucketsVal;
               end
            end else begin
               prod_in = mul_p;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastMod) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cnt_in   = '0;
            found_in = 1'b0;
            free_in  = 1'b0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // one way per cycle through the shared key compare
            if (cur.valid && cur.client0 == cl0_ff && cur.client1 == cl1_ff &&
                cur.create0 == cr0_ff && cur.create1 == cr1_ff && !found_ff) begin
               found_in = 1'b1;
               match_in = cnt_ff[WW-1:0];
            end
            if (!cur.valid && !free_ff) begin
               free_in  = 1'b1;
               freew_in = cnt_ff[WW-1:0];
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LastWay) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            rsp_valid_in = 1'b1;
            status_in    = status_c;
            hout_in      = hout_c;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      type_ff   <= type_in;
      cl0_ff    <= cl0_in;
      cl1_ff    <= cl1_in;
      cr0_ff    <= cr0_in;
      cr1_ff    <= cr1_in;
      replay_ff <= replay_in;
      hin_ff    <= hin_in;
      hash_ff   <= hash_in;
      fold_ff   <= fold_in;
      rem_ff    <= rem_in;
      prod_ff   <= prod_in;
      found_ff  <= found_in;
      free_ff   <= free_in;
      match_ff  <= match_in;
      freew_ff  <= freew_in;
      status_ff <= status_in;
      hout_ff   <= hout_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_handle_out = hout_ff;

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for replay_reservation_table
// drives lookup/set/clear and invalid-type words from a directed table and random key pools,
// predicts status and handle with its own table copy; needs rrt_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned NBUCKETS = 256;
   localparam int unsigned NWAYS    = 4;
   localparam int unsigned NENTRIES = NBUCKETS * NWAYS;
   localparam int unsigned WATCHDOG = 20000;
   localparam int unsigned NRANDOM  = 1730;

   typedef struct {
      logic [1:0]  kind;
      logic [63:0] cl0, cl1, cr0, cr1;
      logic        replay;
      logic [31:0] hin;
   } req_word_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] handle;
   } rsp_word_type;

   // directed row: the word plus an optional typed-in answer
   typedef struct {
      req_word_type word;
      logic         typed;
      logic [2:0]   status;
      logic [31:0]  handle;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_type = '0;
   logic [63:0] req_client_id_word0 = '0;
   logic [63:0] req_client_id_word1 = '0;
   logic [63:0] req_create_id_word0 = '0;
   logic [63:0] req_create_id_word1 = '0;
   logic        req_replay_flag = 1'b0;
   logic [31:0] req_handle_in = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_handle_out;

   replay_reservation_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_type(req_type),
      .req_client_id_word0(req_client_id_word0),
      .req_client_id_word1(req_client_id_word1),
      .req_create_id_word0(req_create_id_word0),
      .req_create_id_word1(req_create_id_word1),
      .req_replay_flag(req_replay_flag), .req_handle_in(req_handle_in),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_handle_out(rsp_handle_out)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow copy of the table
   logic        sh_valid [NENTRIES];
   logic        sh_attached [NENTRIES];
   logic [63:0] sh_cl0 [NENTRIES], sh_cl1 [NENTRIES], sh_cr0 [NENTRIES], sh_cr1 [NENTRIES];
   logic [31:0] sh_handle [NENTRIES];

   rsp_word_type pending_rsp [$];
   int          fail_count = 0;
   int          accepted = 0;
   int          responses = 0;
   int          idle_cycles = 0;
   int          sender_gap_pct = 0;
   int          status_seen [8];

   // bucket index from the multiply-by-31 fold (client word0 is not hashed)
   function automatic int unsigned bucket_of(logic [63:0] cl1, logic [63:0] cr0,
                                              logic [63:0] cr1);
      logic [63:0] h;
      logic [31:0] folded;
      h = cr0;
      h = h * 64'(rrt_pkg::HashMul) + cl1;
      h = h * 64'(rrt_pkg::HashMul) + cr0;
      h = h * 64'(rrt_pkg::HashMul) + cr1;
      folded = h[63:32] ^ h[31:0];
      return folded % NBUCKETS;
   endfunction

   // applies one word to the shadow table and returns the answer it gives
   function automatic rsp_word_type table_apply(req_word_type w);
      rsp_word_type r;
      int unsigned base;
      int          hit;
      base = bucket_of(w.cl1, w.cr0, w.cr1) * NWAYS;
      hit = -1;
      r.status = rrt_pkg::ST_MISSING;
      r.handle = '0;
      for (int i = 0; i < NWAYS; i++) begin
         if (hit < 0 && sh_valid[base+i] && sh_cl0[base+i] == w.cl0 &&
             sh_cl1[base+i] == w.cl1 && sh_cr0[base+i] == w.cr0 &&
             sh_cr1[base+i] == w.cr1)
            hit = base + i;
      end
      case (w.kind)
         rrt_pkg::REQ_LOOKUP: begin
            if (hit < 0) begin
               r.status = rrt_pkg::ST_FULL;
               for (int i = 0; i < NWAYS; i++) begin
                  if (r.status == rrt_pkg::ST_FULL && !sh_valid[base+i]) begin
                     sh_valid[base+i] = 1'b1;
                     sh_attached[base+i] = 1'b0;
                     sh_cl0[base+i] = w.cl0;
                     sh_cl1[base+i] = w.cl1;
                     sh_cr0[base+i] = w.cr0;
                     sh_cr1[base+i] = w.cr1;
                     r.status = rrt_pkg::ST_RESERVED;
                  end
               end
            end else if (sh_attached[hit]) begin
               if (w.replay) begin
                  r.status = rrt_pkg::ST_OK;
                  r.handle = sh_handle[hit];
               end else r.status = rrt_pkg::ST_DUPLICATE;
            end else r.status = rrt_pkg::ST_PENDING;
         end
         rrt_pkg::REQ_SET: begin
            if (hit >= 0 && !sh_attached[hit]) begin
               sh_attached[hit] = 1'b1;
               sh_handle[hit] = w.hin;
               r.status = rrt_pkg::ST_OK;
            end
         end
         rrt_pkg::REQ_CLEAR: begin
            if (hit >= 0) begin
               sh_valid[hit] = 1'b0;
               sh_attached[hit] = 1'b0;
               r.status = rrt_pkg::ST_OK;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at word %0d", what, got, want, responses);
      fail_count++;
   endtask

   // response checker: strobe sampled at the edge that ends its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) report_mismatch("unexpected response", rsp_status, 0);
         else begin
            rsp_word_type want;
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_handle_out !== want.handle)
               report_mismatch("handle", rsp_handle_out, want.handle);
            status_seen[want.status & 3'd7]++;
         end
         responses++;
      end
   end

   // watchdog: cycles with nothing accepted or answered
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("tb: failure");
         $finish;
      end
   end

   // drives one word and waits for the edge that takes it; start stays high
   // across back-to-back words unless a random gap drops it, never dropped and raised in one step
   task automatic send_word(req_word_type w, logic typed, logic [2:0] st, logic [31:0] hd);
      rsp_word_type p;
      while (sender_gap_pct > 0 && $urandom_range(99, 0) < sender_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_type <= w.kind;
      req_client_id_word0 <= w.cl0;
      req_client_id_word1 <= w.cl1;
      req_create_id_word0 <= w.cr0;
      req_create_id_word1 <= w.cr1;
      req_replay_flag <= w.replay;
      req_handle_in <= w.hin;
      do @(posedge clock); while (busy);
      // taken at this edge: predict in acceptance order
      p = table_apply(w);
      if (typed) begin
         p.status = st;
         p.handle = hd;
      end
      pending_rsp.push_back(p);
      accepted++;
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // random key pools: a few shared keys so hits, pending and duplicates are common
   logic [63:0] pool [16][4];
   logic [63:0] full_keys [6][4];

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic req_word_type make_word(logic [1:0] k, logic [63:0] key [4],
                                              logic rp, logic [31:0] h);
      req_word_type w;
      w.kind = k; w.cl0 = key[0]; w.cl1 = key[1]; w.cr0 = key[2]; w.cr1 = key[3];
      w.replay = rp; w.hin = h;
      return w;
   endfunction

   row_type     plan [$];
   logic [63:0] k_ones [4], k_zero [4], k_a [4];

   initial begin
      req_word_type w;
      for (int i = 0; i < NENTRIES; i++) begin
         sh_valid[i] = 1'b0;
         sh_attached[i] = 1'b0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // keys at the extremes plus one random one
      foreach (k_ones[i]) begin
         k_ones[i] = '1;
         k_zero[i] = '0;
         k_a[i] = rand64();
      end
      // directed table: typed answers only where obvious from an empty table
      plan.push_back('{make_word(rrt_pkg::REQ_SET, k_zero, 1'b0, '1), 1'b1,
                       rrt_pkg::ST_MISSING, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_CLEAR, k_ones, 1'b0, '0), 1'b1,
                       rrt_pkg::ST_MISSING, '0});
      plan.push_back('{make_word(2'd3, k_zero, 1'b1, '1), 1'b1, rrt_pkg::ST_MISSING, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_zero, 1'b0, '0), 1'b1,
                       rrt_pkg::ST_RESERVED, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_zero, 1'b1, '0), 1'b1,
                       rrt_pkg::ST_PENDING, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_SET, k_zero, 1'b0, '0), 1'b1,
                       rrt_pkg::ST_OK, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_SET, k_zero, 1'b0, '1), 1'b1,
                       rrt_pkg::ST_MISSING, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_zero, 1'b1, '1), 1'b1,
                       rrt_pkg::ST_OK, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_zero, 1'b0, '0), 1'b1,
                       rrt_pkg::ST_DUPLICATE, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_ones, 1'b0, '0), 1'b1,
                       rrt_pkg::ST_RESERVED, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_SET, k_ones, 1'b1, '1), 1'b1,
                       rrt_pkg::ST_OK, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_ones, 1'b1, '0), 1'b1,
                       rrt_pkg::ST_OK, '1});
      plan.push_back('{make_word(rrt_pkg::REQ_CLEAR, k_ones, 1'b0, '0), 1'b1,
                       rrt_pkg::ST_OK, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_ones, 1'b1, '0), 1'b1,
                       rrt_pkg::ST_RESERVED, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_CLEAR, k_ones, 1'b0, '0), 1'b1,
                       rrt_pkg::ST_OK, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_LOOKUP, k_a, 1'b0, '0), 1'b0,
                       rrt_pkg::ST_OK, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_CLEAR, k_a, 1'b0, '0), 1'b0,
                       rrt_pkg::ST_OK, '0});
      plan.push_back('{make_word(rrt_pkg::REQ_CLEAR, k_zero, 1'b0, '0), 1'b0,
                       rrt_pkg::ST_OK, '0});
      foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].status, plan[i].handle);
      drain();

      // fill one bucket past its ways: vary client word0, which the hash skips
      for (int i = 0; i < 6; i++) begin
         full_keys[i][0] = rand64();
         full_keys[i][1] = k_a[1];
         full_keys[i][2] = k_a[2];
         full_keys[i][3] = k_a[3];
      end
      for (int i = 0; i < 6; i++)
         send_word(make_word(rrt_pkg::REQ_LOOKUP, full_keys[i], 1'b0, '0), 1'b0,
                   rrt_pkg::ST_OK, '0);
      send_word(make_word(rrt_pkg::REQ_CLEAR, full_keys[1], 1'b0, '0), 1'b0,
                rrt_pkg::ST_OK, '0);
      send_word(make_word(rrt_pkg::REQ_LOOKUP, full_keys[5], 1'b0, '0), 1'b0,
                rrt_pkg::ST_OK, '0);
      // pause until the table is quiet
      drain();

      // random part: three idling phases
      for (int i = 0; i < 16; i++) begin
         for (int j = 0; j < 4; j++) pool[i][j] = rand64();
         // half the pool collides on the hashed words to exercise full buckets
         if (i >= 8) begin
            pool[i][1] = pool[8][1];
            pool[i][2] = pool[8][2];
            pool[i][3] = pool[8][3];
         end
      end
      for (int i = 0; i < NRANDOM; i++) begin
         int pick;
         if (i == 0) sender_gap_pct = 9;
         else if (i == NRANDOM / 3) sender_gap_pct = 73;
         else if (i == 2 * NRANDOM / 3) sender_gap_pct = 0;
         pick = $urandom_range(15, 0);
         w = make_word(2'($urandom_range(9, 0) < 9 ? $urandom_range(2, 0) : 3),
                       pool[pick], 1'($urandom()), $urandom());
         // some noise keys, never seen before
         if ($urandom_range(9, 0) == 0) begin
            w.cl0 = rand64(); w.cl1 = rand64(); w.cr0 = rand64(); w.cr1 = rand64();
         end
         send_word(w, 1'b0, rrt_pkg::ST_OK, '0);
      end
      drain();
      repeat (60) @(posedge clock);

      $display("covered %0d words: ok %0d reserved %0d duplicate %0d pending %0d",
               accepted, status_seen[rrt_pkg::ST_OK], status_seen[rrt_pkg::ST_RESERVED],
               status_seen[rrt_pkg::ST_DUPLICATE], status_seen[rrt_pkg::ST_PENDING]);
      $display("full bucket %0d, missing or misuse %0d", status_seen[rrt_pkg::ST_FULL],
               status_seen[rrt_pkg::ST_MISSING]);
      if (fail_count == 0 && pending_rsp.size() == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
